// ===== src/t1ppm_pkg.sv =====
// Package for the type I peak programme meter ballistics block: widths, codes,
// register map, reset values and the configuration struct.
// No dependencies; compile this file first.
`timescale 1ns / 1ps
`default_nettype none

package t1ppm_pkg;

   // Default number of samples taken from each group beat (range 1 to 4; larger values act as 4).
   localparam int GROUP_SIZE_DEFAULT = 4;
   // Sample fields carried by one group beat.
   localparam int SAMPLE_FIELDS = 4;
   localparam int IDX_W = 2;

   localparam int SAMPLE_W = 24;
   localparam int ENV_W = 24;
   localparam int HOLD_W = 25;
   localparam int COEF_W = 24;
   localparam int GAIN_W = 16;
   localparam int LEVEL_W = 25;
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 24;
   localparam int PROD_W = MUL_A_W + MUL_B_W;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Action codes.
   localparam logic [1:0] ACT_GROUP = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Register indexes (byte address is four times the index).
   localparam logic [1:0] REG_ATTACK_SLOW = 2'd0;
   localparam logic [1:0] REG_ATTACK_FAST = 2'd1;
   localparam logic [1:0] REG_DECAY_FACTOR = 2'd2;
   localparam logic [1:0] REG_OUTPUT_GAIN = 2'd3;

   localparam logic [COEF_W-1:0] ATTACK_SLOW_RESET = 24'd157286;
   localparam logic [COEF_W-1:0] ATTACK_FAST_RESET = 24'd454383;
   localparam logic [COEF_W-1:0] DECAY_FACTOR_RESET = 24'd16775329;
   localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RESET = 16'd33476;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [ENV_W-1:0] env_type;
   typedef logic [HOLD_W-1:0] hold_type;
   typedef logic [COEF_W-1:0] coef_type;
   typedef logic [GAIN_W-1:0] gain_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [1:0] action_type;

   typedef struct packed {
      coef_type attack_slow;
      coef_type attack_fast;
      coef_type decay_factor;
      gain_type output_gain;
   } cfg_type;

   // Magnitude of a signed Q0.23 sample as unsigned Q1.23; the most negative
   // sample gives exactly full scale.
   function automatic env_type magnitude(sample_type s);
      logic [SAMPLE_W-1:0] raw;
      raw = s;
      return raw[SAMPLE_W-1] ? (~raw + 24'd1) : raw;
   endfunction

endpackage

`default_nettype wire

// ===== src/t1ppm_if.sv =====
// Handshake channels of the meter block: request beats and response beats.
// Depends on t1ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface t1ppm_req_if;
   import t1ppm_pkg::*;

   logic valid;
   logic ready;
   action_type action;
   sample_type sample_a;
   sample_type sample_b;
   sample_type sample_c;
   sample_type sample_d;

   modport source (output valid, output action, output sample_a, output sample_b,
                   output sample_c, output sample_d, input ready);
   modport sink (input valid, input action, input sample_a, input sample_b,
                 input sample_c, input sample_d, output ready);
endinterface

interface t1ppm_rsp_if;
   import t1ppm_pkg::*;

   logic valid;
   logic ready;
   level_type level;

   modport source (output valid, output level, input ready);
   modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

// ===== src/t1ppm_csr.sv =====
// APB-style configuration registers of the meter block.
// Depends on t1ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module t1ppm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [t1ppm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [t1ppm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [t1ppm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output t1ppm_pkg::cfg_type                  cfg
);
   import t1ppm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [1:0] reg_idx;
   logic write_en;

   assign reg_idx = csr_paddr[3:2];
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_idx)
            REG_ATTACK_SLOW: cfg_in.attack_slow = csr_pwdata[COEF_W-1:0];
            REG_ATTACK_FAST: cfg_in.attack_fast = csr_pwdata[COEF_W-1:0];
            REG_DECAY_FACTOR: cfg_in.decay_factor = csr_pwdata[COEF_W-1:0];
            REG_OUTPUT_GAIN: cfg_in.output_gain = csr_pwdata[GAIN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ATTACK_SLOW: csr_prdata = CSR_DATA_W'(cfg_ff.attack_slow);
         REG_ATTACK_FAST: csr_prdata = CSR_DATA_W'(cfg_ff.attack_fast);
         REG_DECAY_FACTOR: csr_prdata = CSR_DATA_W'(cfg_ff.decay_factor);
         REG_OUTPUT_GAIN: csr_prdata = CSR_DATA_W'(cfg_ff.output_gain);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_slow <= ATTACK_SLOW_RESET;
         cfg_ff.attack_fast <= ATTACK_FAST_RESET;
         cfg_ff.decay_factor <= DECAY_FACTOR_RESET;
         cfg_ff.output_gain <= OUTPUT_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/t1ppm_mul.sv =====
// Shared unsigned multiplier of the meter block with a registered product.
// Depends on t1ppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module t1ppm_mul (
   input  wire logic                           clock,
   input  wire logic [t1ppm_pkg::MUL_A_W-1:0]  op_a,
   input  wire logic [t1ppm_pkg::MUL_B_W-1:0]  op_b,
   output logic      [t1ppm_pkg::PROD_W-1:0]   product
);
   import t1ppm_pkg::*;

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign product = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire

// ===== src/type1_ppm_ballistics_core.sv =====
// Top level of the type I peak programme meter ballistics block.
// Depends on t1ppm_pkg, t1ppm_if, t1ppm_csr and t1ppm_mul.
`timescale 1ns / 1ps
`default_nettype none

// A group beat carries four signed Q0.23 samples, of which the first
// GROUP_SIZE (at most four) are used. The block decays the slow and fast
// envelope followers by decay_factor, then lets each follower that lies below
// a sample magnitude move toward it by its attack coefficient, and finally
// lets the peak hold take the larger of itself and the sum of both followers.
// A read beat returns output_gain times the peak hold as one response beat
// and makes the next group start its hold from zero; a clear beat zeroes all
// meter state and gives no response. All arithmetic runs on one shared
// 25 x 24 bit multiplier, one multiply issued per cycle under a step counter,
// the slow and fast followers alternating so that each write-back lands
// before that follower is used again. A group runs through the multiply
// steps, a drain state and a summing state before the next request can be
// taken; a read runs through a multiply state and an output state, where it
// also holds while the previous response is still waiting to be taken; a
// clear or an unused action code leaves the block idle. The request side is
// not ready while a beat is being worked on. A finished response sits in an
// output register, so the next request is accepted while that response waits.
// Configuration registers are written through the csr_ port and should only
// change while the block is idle.
module type1_ppm_ballistics_core #(
   parameter int GROUP_SIZE = t1ppm_pkg::GROUP_SIZE_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   t1ppm_req_if.sink                             req_chan,
   t1ppm_rsp_if.source                           rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [t1ppm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [t1ppm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [t1ppm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                  csr_pready
);
   import t1ppm_pkg::*;

   // Samples actually used per group, and the multiply steps they take:
   // two decays, then one attack per follower per sample.
   localparam int USED = (GROUP_SIZE < SAMPLE_FIELDS) ? GROUP_SIZE : SAMPLE_FIELDS;
   localparam int STEPS = 2 + 2 * USED;
   localparam int STEP_W = $clog2(STEPS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_SUM,
      S_READ_MUL,
      S_READ_OUT
   } state_type;

   // Describes the multiply in flight, for its write-back in the following cycle.
   typedef struct packed {
      logic valid;
      logic fast;
      logic attack;
      logic apply;
   } pend_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   pend_type pend_ff, pend_in;
   env_type slow_ff, slow_in;
   env_type fast_ff, fast_in;
   hold_type peak_ff, peak_in;
   logic restart_ff, restart_in;
   logic rsp_valid_ff, rsp_valid_in;
   level_type level_ff, level_in;
   logic [SAMPLE_W-1:0] samples_ff [SAMPLE_FIELDS];
   logic [SAMPLE_W-1:0] samples_in [SAMPLE_FIELDS];

   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [PROD_W-1:0] product;

   logic req_fire;
   logic op_fast;
   logic op_decay;
   logic [STEP_W-1:0] att_step;
   logic [IDX_W-1:0] sample_idx;
   env_type mag;
   env_type env_sel;
   coef_type coef_sel;
   logic apply;
   env_type diff;
   env_type scaled;
   env_type wb_base;
   env_type wb_env;
   hold_type env_sum;
   hold_type hold_base;

   t1ppm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   t1ppm_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.level = level_ff;

   // Operand selection for the step being issued. Even steps belong to the
   // slow follower and odd steps to the fast one.
   assign op_fast = step_ff[0];
   assign op_decay = (step_ff < STEP_W'(2));
   assign att_step = step_ff - STEP_W'(2);
   assign sample_idx = IDX_W'(att_step >> 1);
   assign mag = magnitude(samples_ff[sample_idx]);
   assign env_sel = op_fast ? fast_ff : slow_ff;
   assign coef_sel = op_fast ? cfg.attack_fast : cfg.attack_slow;
   assign apply = (mag > env_sel);
   assign diff = mag - env_sel;

   // The reading operands stay on the multiplier while the response waits for
   // the output register, so the product is still valid when it is taken.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_RUN: begin
            if (op_decay) begin
               op_a = MUL_A_W'(env_sel);
               op_b = cfg.decay_factor;
            end else begin
               op_a = MUL_A_W'(diff);
               op_b = coef_sel;
            end
         end
         S_READ_MUL, S_READ_OUT: begin
            op_a = peak_ff;
            op_b = MUL_B_W'(cfg.output_gain);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Write-back of the previous multiply: a decay replaces the follower, an
   // attack adds the scaled distance when the sample lay above the follower.
   assign scaled = product[47:24];
   assign wb_base = pend_ff.fast ? fast_ff : slow_ff;
   assign wb_env = pend_ff.attack ? (pend_ff.apply ? wb_base + scaled : wb_base) : scaled;

   assign env_sum = HOLD_W'(slow_ff) + HOLD_W'(fast_ff);
   assign hold_base = restart_ff ? '0 : peak_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      pend_in = '0;
      slow_in = slow_ff;
      fast_in = fast_ff;
      peak_in = peak_ff;
      restart_in = restart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      level_in = level_ff;
      samples_in = samples_ff;

      if (pend_ff.valid) begin
         if (pend_ff.fast) begin
            fast_in = wb_env;
         end else begin
            slow_in = wb_env;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_GROUP: begin
                     samples_in[0] = req_chan.sample_a;
                     samples_in[1] = req_chan.sample_b;
                     samples_in[2] = req_chan.sample_c;
                     samples_in[3] = req_chan.sample_d;
                     step_in = '0;
                     state_in = S_RUN;
                  end
                  ACT_READ: begin
                     restart_in = 1'b1;
                     state_in = S_READ_MUL;
                  end
                  ACT_CLEAR: begin
                     slow_in = '0;
                     fast_in = '0;
                     peak_in = '0;
                     restart_in = 1'b1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RUN: begin
            pend_in.valid = 1'b1;
            pend_in.fast = op_fast;
            pend_in.attack = !op_decay;
            pend_in.apply = apply;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            peak_in = (env_sum > hold_base) ? env_sum : hold_base;
            restart_in = 1'b0;
            state_in = S_IDLE;
         end
         S_READ_MUL: begin
            state_in = S_READ_OUT;
         end
         S_READ_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               level_in = product[40:16];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         pend_ff <= '0;
         slow_ff <= '0;
         fast_ff <= '0;
         peak_ff <= '0;
         restart_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         pend_ff <= pend_in;
         slow_ff <= slow_in;
         fast_ff <= fast_in;
         peak_ff <= peak_in;
         restart_ff <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff <= level_in;
      samples_ff <= samples_in;
   end

endmodule

`default_nettype wire
